>>> rtl/bsort_pkg.sv
// ----------------------------------------------------------------------------
// bsort_pkg
// shared types and constants for the bubble sort block with swap count
// ----------------------------------------------------------------------------
package bsort_pkg;

  localparam int DATA_W        = 32;
  localparam int SWAP_W        = 9;
  localparam int MAX_ITEMS_DEF = 32;

  // one input transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic [SWAP_W-1:0]        swap_total;
    logic                     overflowed;
    logic                     last_result;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic sort_init;
    logic pass_start;
    logic pass_load;
    logic pass_cmp;
    logic pass_end;
    logic emit_start;
    logic emit_ld;
    logic emit_next;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic top_le1;
    logic cmp_last;
    logic emit_last;
  } status_t;

endpackage

>>> rtl/bsort_dp.sv
// ----------------------------------------------------------------------------
// bsort_dp
// element memory, bubbling carry register, counters and result register
// ----------------------------------------------------------------------------
module bsort_dp #(
  parameter int MAX_ITEMS = bsort_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bsort_pkg::item_t   item,
  input  bsort_pkg::cmd_t    cmd,
  output bsort_pkg::status_t status,
  output bsort_pkg::result_t result
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int DW = bsort_pkg::DATA_W;
  localparam int SW = bsort_pkg::SWAP_W;

  logic signed [DW-1:0] mem [MAX_ITEMS];
  logic signed [DW-1:0] rd_data;
  logic signed [DW-1:0] carry;
  logic [CW-1:0]        count;
  logic [CW-1:0]        top;
  logic [AW-1:0]        idx;
  logic                 ovf;
  logic [SW-1:0]        swap;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic signed [DW-1:0] wdata;
  logic [AW-1:0]        raddr;
  logic [CW-1:0]        top_m1;
  logic                 gt;
  logic                 has_room;

  assign top_m1   = top - CW'(1);
  assign gt       = carry > rd_data;
  assign has_room = count < CW'(MAX_ITEMS);

  assign status.top_le1   = top <= CW'(1);
  assign status.cmp_last  = CW'(idx) == top_m1;
  assign status.emit_last = CW'(idx) == (count - CW'(1));

  // write enable, write address and data, and read address selection
  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = item.value;
    raddr = idx;
    if (cmd.load && has_room) begin
      we = 1'b1;
    end
    if (cmd.pass_cmp) begin
      we    = 1'b1;
      waddr = idx - AW'(1);
      wdata = gt ? rd_data : carry;
      raddr = idx + AW'(1);
    end
    if (cmd.pass_end) begin
      we    = 1'b1;
      waddr = top_m1[AW-1:0];
      wdata = carry;
    end
    if (cmd.pass_start) begin
      raddr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_load) begin
      carry <= rd_data;
    end else if (cmd.pass_cmp && !gt) begin
      carry <= rd_data;
    end
    if (cmd.emit_ld) begin
      result.sorted_value <= rd_data;
      result.swap_total   <= swap;
      result.overflowed   <= ovf;
      result.last_result  <= status.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      top   <= '0;
      idx   <= '0;
      ovf   <= 1'b0;
      swap  <= '0;
    end else begin
      if (cmd.load) begin
        if (has_room) begin
          count <= count + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.sort_init) begin
        top  <= count;
        swap <= '0;
      end
      if (cmd.pass_start) begin
        idx <= AW'(1);
      end
      if (cmd.pass_cmp) begin
        idx <= idx + AW'(1);
        if (gt && swap != {SW{1'b1}}) begin
          swap <= swap + SW'(1);
        end
      end
      if (cmd.pass_end) begin
        top <= top_m1;
      end
      if (cmd.emit_start) begin
        idx <= '0;
      end
      if (cmd.emit_next) begin
        idx <= idx + AW'(1);
      end
      if (cmd.clear) begin
        count <= '0;
        swap  <= '0;
        ovf   <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/bsort_ctrl.sv
// ----------------------------------------------------------------------------
// bsort_ctrl
// sequencer for load, sort passes and result emission
// ----------------------------------------------------------------------------
module bsort_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_last,
  input  logic               result_stall,
  input  bsort_pkg::status_t status,
  output bsort_pkg::cmd_t    cmd,
  output logic               item_stall,
  output logic               result_valid
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SORT_INIT = 4'd1;
  localparam logic [3:0] S_PASS_CHK  = 4'd2;
  localparam logic [3:0] S_PASS_LD   = 4'd3;
  localparam logic [3:0] S_PASS_CMP  = 4'd4;
  localparam logic [3:0] S_PASS_END  = 4'd5;
  localparam logic [3:0] S_EMIT_RD   = 4'd6;
  localparam logic [3:0] S_EMIT_LD   = 4'd7;
  localparam logic [3:0] S_EMIT_WT   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign item_stall   = state != S_IDLE;
  assign result_valid = state == S_EMIT_WT;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load = 1'b1;
          if (item_last) begin
            state_next = S_SORT_INIT;
          end
        end
      end
      S_SORT_INIT: begin
        cmd.sort_init = 1'b1;
        state_next    = S_PASS_CHK;
      end
      S_PASS_CHK: begin
        if (status.top_le1) begin
          cmd.emit_start = 1'b1;
          state_next     = S_EMIT_RD;
        end else begin
          cmd.pass_start = 1'b1;
          state_next     = S_PASS_LD;
        end
      end
      S_PASS_LD: begin
        cmd.pass_load = 1'b1;
        state_next    = S_PASS_CMP;
      end
      S_PASS_CMP: begin
        cmd.pass_cmp = 1'b1;
        if (status.cmp_last) begin
          state_next = S_PASS_END;
        end
      end
      S_PASS_END: begin
        cmd.pass_end = 1'b1;
        state_next   = S_PASS_CHK;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_next  = S_EMIT_WT;
      end
      S_EMIT_WT: begin
        if (!result_stall) begin
          if (status.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_next    = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/bubble_sort_with_swap_count.sv
// load: a transaction is taken while idle; after the last one the sort of n
//   elements runs an init step, then passes of check, load, compares and end
// throughput: one compare per cycle on a single memory read port; each result
//   is then read, registered and handed over, and waits out any output stall
// reset: rst is synchronous and active high; it empties the set and clears
//   the swap count and overflow flag; the element memory is not cleared
// ----------------------------------------------------------------------------
// bubble_sort_with_swap_count
// collects signed values, bubble sorts them ascending while counting swaps,
// then emits the sorted set with the swap total on every result
// ----------------------------------------------------------------------------
module bubble_sort_with_swap_count #(
  parameter int MAX_ITEMS = bsort_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input channel, one element per transaction
  input  logic               item_valid,
  output logic               item_stall,
  input  bsort_pkg::item_t   item,
  // output channel, one sorted element per transaction
  output logic               result_valid,
  input  logic               result_stall,
  output bsort_pkg::result_t result
);

  bsort_pkg::cmd_t    cmd;
  bsort_pkg::status_t status;

  // controller: walks load, passes and emission; stalls input outside idle
  bsort_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_last    (item.last_item),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd),
    .item_stall   (item_stall),
    .result_valid (result_valid)
  );

  // datapath: each pass bubbles the running maximum through a carry register,
  // writing the smaller value of every compare back one slot lower
  bsort_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

  // input is never taken while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("input open while result pending");

  // a transaction closing the set starts the sort
  a_last_starts_sort: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.last_item) |=> item_stall)
    else $error("sort did not start after last item");

  // handing over the final result reopens the input
  a_last_reopens: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && result.last_result) |=> !item_stall)
    else $error("input not reopened after final result");

  // a result without the last mark keeps the input closed, as more results follow
  a_more_results: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !result.last_result) |=> item_stall)
    else $error("set ended without last result");

endmodule
